// File: sv/spd_pkg.sv
package spd_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_BOX_LENGTH      = 2'd0,
        REG_CUTOFF_ASPECT   = 2'd1,
        REG_CUTOFF_DIAMETER = 2'd2
    } cfg_reg_t;

    localparam logic [30:0]  BOX_LENGTH_RST      = 31'd4194304;
    localparam logic [15:0]  CUTOFF_ASPECT_RST   = 16'd512;
    localparam logic [15:0]  CUTOFF_DIAMETER_RST = 16'd256;

    localparam logic [36:0]  NEAR_NUM  = 37'd21;
    localparam logic [36:0]  NEAR_DEN  = 37'd20;
    localparam longint       EPS_Q56   = 64'sd7205759;
    localparam logic [40:0]  PARAM_CAP = 41'h100_0000_0000;
    localparam logic signed [15:0] AXIS_MAX = 16'sd16384;
    localparam logic [31:0]  DIST_MAX  = 32'hFFFF_FFFF;
    localparam logic [15:0]  ONE_Q8    = 16'd256;

    // stage map of the pipeline
    localparam int MI_STEPS = 33;
    localparam int SQ_STEPS = 32;
    localparam int DV_STEPS = 41;
    localparam int ST_MI    = 1;
    localparam int ST_WRAP  = ST_MI + MI_STEPS;
    localparam int ST_MUL   = ST_WRAP + 1;
    localparam int ST_SUM   = ST_MUL + 1;
    localparam int ST_SQA   = ST_SUM + 1;
    localparam int ST_RND   = ST_SUM + 1;
    localparam int ST_DEN   = ST_RND + 1;
    localparam int ST_NUM   = ST_DEN + 1;
    localparam int ST_DIVI  = ST_NUM + 1;
    localparam int ST_DIV   = ST_DIVI + 1;
    localparam int ST_PAR   = ST_DIV + DV_STEPS;
    localparam int ST_CL1   = ST_PAR + 1;
    localparam int ST_CL2   = ST_CL1 + 1;
    localparam int ST_CL3   = ST_CL2 + 1;
    localparam int ST_CL4   = ST_CL3 + 1;
    localparam int ST_FP    = ST_CL4 + 1;
    localparam int ST_FD    = ST_FP + 1;
    localparam int ST_FM    = ST_FD + 1;
    localparam int ST_FSQ   = ST_FM + 1;
    localparam int ST_FSUM  = ST_FSQ + 1;
    localparam int ST_SQB   = ST_FSUM + 1;
    localparam int N_ST     = ST_SQB + SQ_STEPS;

    // payload carried by every stage
    typedef struct packed {
        logic [32:0]        ax;
        logic [32:0]        ay;
        logic               negx;
        logic               negy;
        logic [32:0]        remx;
        logic [32:0]        remy;
        logic               parx;
        logic               pary;
        logic signed [32:0] rx;
        logic signed [32:0] ry;
        logic signed [15:0] eix;
        logic signed [15:0] eiy;
        logic signed [15:0] ejx;
        logic signed [15:0] ejy;
        logic [30:0]        lhi;
        logic [30:0]        lhj;
        logic [63:0]        sqx;
        logic [63:0]        sqy;
        logic [63:0]        v1;
        logic [63:0]        r1;
        logic signed [48:0] pix;
        logic signed [48:0] piy;
        logic signed [48:0] pjx;
        logic signed [48:0] pjy;
        logic signed [31:0] eex;
        logic signed [31:0] eey;
        logic signed [49:0] rei30;
        logic signed [49:0] rej30;
        logic signed [31:0] eiej;
        logic signed [34:0] rei;
        logic signed [34:0] rej;
        logic [63:0]        eesq;
        logic signed [59:0] denom;
        logic               fallback;
        logic signed [63:0] p1;
        logic signed [63:0] p2;
        logic signed [41:0] lamf;
        logic signed [41:0] muf;
        logic [62:0]        nlm;
        logic [62:0]        nmm;
        logic               nln;
        logic               nmn;
        logic [56:0]        dv;
        logic               satl;
        logic               satm;
        logic [56:0]        reml;
        logic [56:0]        remm;
        logic [40:0]        ql;
        logic [40:0]        qm;
        logic signed [41:0] lam;
        logic signed [41:0] mu;
        logic               cond;
        logic               bra;
        logic signed [32:0] pval;
        logic signed [63:0] cprod;
        logic signed [35:0] other;
        logic signed [32:0] lam2;
        logic signed [32:0] mu2;
        logic signed [48:0] fmx;
        logic signed [48:0] fmy;
        logic signed [48:0] flx;
        logic signed [48:0] fly;
        logic signed [49:0] dx30;
        logic signed [49:0] dy30;
        logic [31:0]        mx;
        logic [31:0]        my;
        logic               msat;
        logic [63:0]        dsqx;
        logic [63:0]        dsqy;
        logic               dsat;
        logic [63:0]        v2;
        logic [63:0]        r2;
    } pipe_t;

endpackage

// File: sv/spherocylinder_pair_distance_top.sv
// channel  | direction | handshake                | payload
// item     | in        | item_valid / item_stall  | pos_*, axis_*, aspect_*, diameter_*
// result   | out       | result_valid/result_stall| distance, near_pair
// cfg      | in        | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One pair per cycle is taken unless a stalled result holds the pipeline.
// The bit-serial stages are 33 for the minimum-image divide, 41 for the
// line-parameter divide and 32 for each of the two square roots.
// Reset clears all valid bits and loads the register defaults.
// A stalled result freezes the whole pipeline; the item side stalls in the same cycle.
module spherocylinder_pair_distance_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic signed [31:0] pos_i_x,
    input  logic signed [31:0] pos_i_y,
    input  logic signed [31:0] pos_j_x,
    input  logic signed [31:0] pos_j_y,
    input  logic signed [15:0] axis_i_x,
    input  logic signed [15:0] axis_i_y,
    input  logic signed [15:0] axis_j_x,
    input  logic signed [15:0] axis_j_y,
    input  logic [15:0]        aspect_i,
    input  logic [15:0]        diameter_i,
    input  logic [15:0]        aspect_j,
    input  logic [15:0]        diameter_j,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [31:0]        distance,
    output logic               near_pair,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import spd_pkg::*;

    logic [30:0] box_length_reg;
    logic [15:0] cutoff_aspect_reg;
    logic [15:0] cutoff_diameter_reg;
    logic [36:0] near_thr_reg;
    logic [32:0] lw;

    pipe_t       pipe_reg  [N_ST];
    pipe_t       pipe_next [N_ST];
    logic        vld_reg   [N_ST];
    logic        out_vld_reg;
    logic [31:0] distance_reg;
    logic        near_pair_reg;
    logic [31:0] distance_next;
    logic        near_pair_next;
    logic        adv;

    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
                                                     input int sh);
        logic [63:0] m;
        m = x[63] ? (~x + 64'd1) : x;
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return x[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] x);
        return x[63] ? (~x + 64'd1) : x;
    endfunction

    // value with the sign of s, zero when s is zero
    function automatic logic signed [32:0] sgn_to(input logic [30:0] v,
                                                  input logic signed [41:0] s);
        if (s == 42'sd0)
            return 33'sd0;
        else if (s < 42'sd0)
            return -$signed({2'b00, v});
        else
            return $signed({2'b00, v});
    endfunction

    function automatic logic signed [15:0] clamp_axis(input logic signed [15:0] v);
        if (v > AXIS_MAX)
            return AXIS_MAX;
        else if (v < -AXIS_MAX)
            return -AXIS_MAX;
        else
            return v;
    endfunction

    // configuration, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_length_reg      <= BOX_LENGTH_RST;
            cutoff_aspect_reg   <= CUTOFF_ASPECT_RST;
            cutoff_diameter_reg <= CUTOFF_DIAMETER_RST;
            near_thr_reg        <= NEAR_NUM * 37'(CUTOFF_ASPECT_RST)
                                   * 37'(CUTOFF_DIAMETER_RST);
        end
        else
        begin
            near_thr_reg <= 37'(cutoff_aspect_reg) * 37'(cutoff_diameter_reg) * NEAR_NUM;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_BOX_LENGTH:      box_length_reg      <= cfg_data[30:0];
                    REG_CUTOFF_ASPECT:   cutoff_aspect_reg   <= cfg_data[15:0];
                    REG_CUTOFF_DIAMETER: cutoff_diameter_reg <= cfg_data[15:0];
                    default:             ;
                endcase
            end
        end
    end

    // zero box length wraps at 2^32
    assign lw = (box_length_reg == 31'd0) ? 33'h1_0000_0000 : {2'b00, box_length_reg};

    // global advance: only a stalled result holds the pipe
    assign adv        = !(out_vld_reg && result_stall);
    assign item_stall = !adv;

    // input stage: separations, axis clamp, half lengths
    always_comb
    begin
        pipe_t              nxt;
        logic signed [32:0] drx;
        logic signed [32:0] dry;
        logic [31:0]        hli;
        logic [31:0]        hlj;
        nxt      = '0;
        drx      = 33'(pos_j_x) - 33'(pos_i_x);
        dry      = 33'(pos_j_y) - 33'(pos_i_y);
        nxt.negx = drx[32];
        nxt.negy = dry[32];
        nxt.ax   = drx[32] ? 33'(-drx) : drx;
        nxt.ay   = dry[32] ? 33'(-dry) : dry;
        nxt.eix  = clamp_axis(axis_i_x);
        nxt.eiy  = clamp_axis(axis_i_y);
        nxt.ejx  = clamp_axis(axis_j_x);
        nxt.ejy  = clamp_axis(axis_j_y);
        hli      = (32'(aspect_i) - 32'(ONE_Q8)) * 32'(diameter_i);
        hlj      = (32'(aspect_j) - 32'(ONE_Q8)) * 32'(diameter_j);
        nxt.lhi  = (aspect_i > ONE_Q8) ? hli[31:1] : 31'd0;
        nxt.lhj  = (aspect_j > ONE_Q8) ? hlj[31:1] : 31'd0;
        pipe_next[0] = nxt;
    end

    for (genvar k = 1; k < N_ST; k++)
    begin : g_stage
        localparam int MI_BIT = (k >= ST_MI && k < ST_MI + MI_STEPS) ? 32 - (k - ST_MI) : 0;
        localparam int SA_I   = (k >= ST_SQA && k < ST_SQA + SQ_STEPS) ? 31 - (k - ST_SQA) : 0;
        localparam int SB_I   = (k >= ST_SQB && k < ST_SQB + SQ_STEPS) ? 31 - (k - ST_SQB) : 0;
        localparam int DV_B   = (k >= ST_DIV && k < ST_DIV + DV_STEPS) ? 40 - (k - ST_DIV) : 0;
        localparam int DV_IDX = (DV_B >= 28) ? DV_B - 28 : 0;

        always_comb
        begin
            pipe_t              prv;
            pipe_t              nxt;
            logic [33:0]        tx;
            logic [33:0]        ty;
            logic [33:0]        lw34;
            logic               up;
            logic signed [33:0] res;
            logic signed [33:0] rv;
            logic [31:0]        mrx;
            logic [31:0]        mry;
            logic [63:0]        sbit;
            logic [63:0]        srb;
            logic signed [63:0] tmp;
            logic signed [59:0] den_t;
            logic [34:0]        mr;
            logic signed [63:0] nl_t;
            logic signed [63:0] nm_t;
            logic [49:0]        hi_l;
            logic [49:0]        hi_m;
            logic               nbl;
            logic               nbm;
            logic [57:0]        t58;
            logic [40:0]        qcap;
            logic signed [41:0] qs;
            logic signed [41:0] neg42;
            logic [40:0]        mlam;
            logic [40:0]        mmu;
            logic signed [42:0] aux1;
            logic signed [42:0] aux2;
            logic [35:0]        mo;
            logic signed [35:0] neg36;
            logic [30:0]        lho;
            logic signed [32:0] oc;
            logic [63:0]        mgx;
            logic [63:0]        mgy;
            logic [64:0]        sum65;

            prv  = pipe_reg[k-1];
            nxt  = prv;
            lw34 = {1'b0, lw};

            // minimum image: one quotient bit per stage, only parity is kept
            if (k >= ST_MI && k < ST_MI + MI_STEPS)
            begin
                tx = {prv.remx, prv.ax[MI_BIT]};
                ty = {prv.remy, prv.ay[MI_BIT]};
                nxt.parx = (tx >= lw34);
                nxt.pary = (ty >= lw34);
                nxt.remx = nxt.parx ? 33'(tx - lw34) : tx[32:0];
                nxt.remy = nxt.pary ? 33'(ty - lw34) : ty[32:0];
            end

            // round to nearest image, ties to even
            if (k == ST_WRAP)
            begin
                up  = ({prv.remx, 1'b0} > lw34) || (({prv.remx, 1'b0} == lw34) && prv.parx);
                res = up ? ($signed({1'b0, prv.remx}) - $signed(lw34)) : $signed({1'b0, prv.remx});
                rv  = prv.negx ? -res : res;
                nxt.rx = rv[32:0];
                up  = ({prv.remy, 1'b0} > lw34) || (({prv.remy, 1'b0} == lw34) && prv.pary);
                res = up ? ($signed({1'b0, prv.remy}) - $signed(lw34)) : $signed({1'b0, prv.remy});
                rv  = prv.negy ? -res : res;
                nxt.ry = rv[32:0];
            end

            // squares and projections
            if (k == ST_MUL)
            begin
                rv      = 34'(prv.rx);
                rv      = rv[33] ? -rv : rv;
                mrx     = rv[31:0];
                rv      = 34'(prv.ry);
                rv      = rv[33] ? -rv : rv;
                mry     = rv[31:0];
                nxt.sqx = 64'(mrx) * 64'(mrx);
                nxt.sqy = 64'(mry) * 64'(mry);
                nxt.pix = prv.rx * prv.eix;
                nxt.piy = prv.ry * prv.eiy;
                nxt.pjx = prv.rx * prv.ejx;
                nxt.pjy = prv.ry * prv.ejy;
                nxt.eex = prv.eix * prv.ejx;
                nxt.eey = prv.eiy * prv.ejy;
            end

            if (k == ST_SUM)
            begin
                nxt.v1    = prv.sqx + prv.sqy;
                nxt.r1    = 64'd0;
                nxt.rei30 = prv.pix + prv.piy;
                nxt.rej30 = prv.pjx + prv.pjy;
                nxt.eiej  = prv.eex + prv.eey;
            end

            // centre distance square root, one result bit per stage
            if (k >= ST_SQA && k < ST_SQA + SQ_STEPS)
            begin
                sbit = 64'd1 << (2 * SA_I);
                srb  = prv.r1 + sbit;
                if (prv.v1 >= srb)
                begin
                    nxt.v1 = prv.v1 - srb;
                    nxt.r1 = (prv.r1 >> 1) + sbit;
                end
                else
                begin
                    nxt.r1 = prv.r1 >> 1;
                end
            end

            if (k == ST_RND)
            begin
                tmp      = rnd_shift(64'(prv.rei30), 14);
                nxt.rei  = tmp[34:0];
                tmp      = rnd_shift(64'(prv.rej30), 14);
                nxt.rej  = tmp[34:0];
                nxt.eesq = prv.eiej * prv.eiej;
            end

            // denominator, parallel test, fallback parameters
            if (k == ST_DEN)
            begin
                den_t        = $signed((60'd1 << 56) - prv.eesq[59:0]);
                nxt.denom    = den_t;
                nxt.fallback = (64'(den_t) <= EPS_Q56);
                nxt.p1       = prv.eiej * prv.rej;
                nxt.p2       = prv.eiej * prv.rei;
                mr           = prv.rei[34] ? 35'(-prv.rei) : prv.rei;
                nxt.lamf     = prv.rei[34] ? -$signed(42'(mr >> 1)) : $signed(42'(mr >> 1));
                mr           = prv.rej[34] ? 35'(-prv.rej) : prv.rej;
                nxt.muf      = prv.rej[34] ? $signed(42'(mr >> 1)) : -$signed(42'(mr >> 1));
            end

            if (k == ST_NUM)
            begin
                nl_t    = (64'(prv.rei) <<< 28) - prv.p1;
                nm_t    = prv.p2 - (64'(prv.rej) <<< 28);
                nxt.nln = nl_t[63];
                nxt.nmn = nm_t[63];
                tmp     = $signed(mag64(nl_t));
                nxt.nlm = tmp[62:0];
                tmp     = $signed(mag64(nm_t));
                nxt.nmm = tmp[62:0];
            end

            // quotient beyond 2^41 saturates; otherwise 41 bits remain
            if (k == ST_DIVI)
            begin
                hi_l     = prv.nlm[62:13];
                hi_m     = prv.nmm[62:13];
                nxt.dv   = prv.denom[56:0];
                nxt.satl = ({7'd0, hi_l} >= prv.denom[56:0]);
                nxt.satm = ({7'd0, hi_m} >= prv.denom[56:0]);
                nxt.reml = {7'd0, hi_l};
                nxt.remm = {7'd0, hi_m};
                nxt.ql   = 41'd0;
                nxt.qm   = 41'd0;
            end

            if (k >= ST_DIV && k < ST_DIV + DV_STEPS)
            begin
                nbl      = (DV_B >= 28) ? prv.nlm[DV_IDX] : 1'b0;
                nbm      = (DV_B >= 28) ? prv.nmm[DV_IDX] : 1'b0;
                t58      = {prv.reml, nbl};
                nxt.ql   = {prv.ql[39:0], (t58 >= {1'b0, prv.dv})};
                nxt.reml = (t58 >= {1'b0, prv.dv}) ? 57'(t58 - {1'b0, prv.dv}) : t58[56:0];
                t58      = {prv.remm, nbm};
                nxt.qm   = {prv.qm[39:0], (t58 >= {1'b0, prv.dv})};
                nxt.remm = (t58 >= {1'b0, prv.dv}) ? 57'(t58 - {1'b0, prv.dv}) : t58[56:0];
            end

            if (k == ST_PAR)
            begin
                qcap    = (prv.satl || prv.ql > PARAM_CAP) ? PARAM_CAP : prv.ql;
                qs      = $signed({1'b0, qcap});
                nxt.lam = prv.fallback ? prv.lamf : (prv.nln ? -qs : qs);
                qcap    = (prv.satm || prv.qm > PARAM_CAP) ? PARAM_CAP : prv.qm;
                qs      = $signed({1'b0, qcap});
                nxt.mu  = prv.fallback ? prv.muf : (prv.nmn ? -qs : qs);
            end

            // clamp: pick the parameter that overshoots most
            if (k == ST_CL1)
            begin
                neg42    = -prv.lam;
                mlam     = prv.lam[41] ? neg42[40:0] : prv.lam[40:0];
                neg42    = -prv.mu;
                mmu      = prv.mu[41] ? neg42[40:0] : prv.mu[40:0];
                nxt.cond = (mlam > 41'(prv.lhi)) || (mmu > 41'(prv.lhj));
                aux1     = $signed({2'b00, mlam}) - $signed({12'd0, prv.lhi});
                aux2     = $signed({2'b00, mmu}) - $signed({12'd0, prv.lhj});
                nxt.bra  = (aux1 > aux2);
                nxt.pval = (aux1 > aux2) ? sgn_to(prv.lhi, prv.lam) : sgn_to(prv.lhj, prv.mu);
            end

            if (k == ST_CL2)
            begin
                nxt.cprod = prv.pval * prv.eiej;
            end

            if (k == ST_CL3)
            begin
                tmp       = rnd_shift(prv.cprod, 28);
                nxt.other = prv.bra ? (tmp[35:0] - 36'(prv.rej)) : (tmp[35:0] + 36'(prv.rei));
            end

            if (k == ST_CL4)
            begin
                neg36 = -prv.other;
                mo    = prv.other[35] ? neg36 : prv.other;
                lho   = prv.bra ? prv.lhj : prv.lhi;
                oc    = (mo > 36'(lho)) ? sgn_to(lho, 42'(prv.other)) : prv.other[32:0];
                if (!prv.cond)
                begin
                    nxt.lam2 = prv.lam[32:0];
                    nxt.mu2  = prv.mu[32:0];
                end
                else if (prv.bra)
                begin
                    nxt.lam2 = prv.pval;
                    nxt.mu2  = oc;
                end
                else
                begin
                    nxt.lam2 = oc;
                    nxt.mu2  = prv.pval;
                end
            end

            // segment separation
            if (k == ST_FP)
            begin
                nxt.fmx = prv.mu2 * prv.ejx;
                nxt.fmy = prv.mu2 * prv.ejy;
                nxt.flx = prv.lam2 * prv.eix;
                nxt.fly = prv.lam2 * prv.eiy;
            end

            if (k == ST_FD)
            begin
                nxt.dx30 = (50'(prv.rx) <<< 14) + 50'(prv.fmx) - 50'(prv.flx);
                nxt.dy30 = (50'(prv.ry) <<< 14) + 50'(prv.fmy) - 50'(prv.fly);
            end

            if (k == ST_FM)
            begin
                mgx      = mag64(rnd_shift(64'(prv.dx30), 14));
                mgy      = mag64(rnd_shift(64'(prv.dy30), 14));
                nxt.msat = (mgx > 64'(DIST_MAX)) || (mgy > 64'(DIST_MAX));
                nxt.mx   = mgx[31:0];
                nxt.my   = mgy[31:0];
            end

            if (k == ST_FSQ)
            begin
                nxt.dsqx = 64'(prv.mx) * 64'(prv.mx);
                nxt.dsqy = 64'(prv.my) * 64'(prv.my);
            end

            if (k == ST_FSUM)
            begin
                sum65    = {1'b0, prv.dsqx} + {1'b0, prv.dsqy};
                nxt.dsat = prv.msat || sum65[64];
                nxt.v2   = sum65[63:0];
                nxt.r2   = 64'd0;
            end

            // segment distance square root
            if (k >= ST_SQB && k < ST_SQB + SQ_STEPS)
            begin
                sbit = 64'd1 << (2 * SB_I);
                srb  = prv.r2 + sbit;
                if (prv.v2 >= srb)
                begin
                    nxt.v2 = prv.v2 - srb;
                    nxt.r2 = (prv.r2 >> 1) + sbit;
                end
                else
                begin
                    nxt.r2 = prv.r2 >> 1;
                end
            end

            pipe_next[k] = nxt;
        end
    end

    // near test and result select
    always_comb
    begin
        pipe_t       last;
        logic [31:0] s;
        last           = pipe_reg[N_ST-1];
        s              = last.r1[31:0];
        near_pair_next = ((37'(s) * NEAR_DEN) < near_thr_reg);
        if (near_pair_next)
            distance_next = last.dsat ? DIST_MAX : last.r2[31:0];
        else
            distance_next = s;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < N_ST; i++)
            begin
                pipe_reg[i] <= pipe_next[i];
            end
            distance_reg  <= distance_next;
            near_pair_reg <= near_pair_next;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N_ST; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= item_valid;
            for (int i = 1; i < N_ST; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            out_vld_reg <= vld_reg[N_ST-1];
        end
    end

    assign result_valid = out_vld_reg;
    assign distance     = distance_reg;
    assign near_pair    = near_pair_reg;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import spd_pkg::*;

    // One pair of spherocylinders as presented on the item port
    typedef struct {
        logic signed [31:0] pix, piy, pjx, pjy;
        logic signed [15:0] eix, eiy, ejx, ejy;
        logic [15:0]        asi, dii, asj, dij;
    } pair_t;

    typedef struct {
        logic [31:0] dval;
        logic        near;
    } dist_res_t;

    // Scoreboard: computes the expected distance for each pair and holds it in order
    class pair_distance_board;
        logic [30:0] box_len;
        logic [15:0] cut_asp;
        logic [15:0] cut_dia;
        dist_res_t   pending[$];
        int          n_checked;

        function new();
            box_len = BOX_LENGTH_RST;
            cut_asp = CUTOFF_ASPECT_RST;
            cut_dia = CUTOFF_DIAMETER_RST;
            n_checked = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [31:0] val);
            case (idx)
                REG_BOX_LENGTH:      box_len = val[30:0];
                REG_CUTOFF_ASPECT:   cut_asp = val[15:0];
                REG_CUTOFF_DIAMETER: cut_dia = val[15:0];
                default: ;
            endcase
        endfunction

        static function logic [63:0] umag(longint x);
            return x < 0 ? 64'(-x) : 64'(x);
        endfunction

        // round to nearest, ties away from zero
        static function longint rshift_rnd(longint x, int s);
            logic [63:0] m;
            m = (umag(x) + (64'd1 << (s - 1))) >> s;
            return x < 0 ? -longint'(m) : longint'(m);
        endfunction

        static function longint min_image(longint dr, logic [30:0] len);
            logic [63:0] lw, a, n, r;
            longint res;
            lw = (len == 0) ? 64'h1_0000_0000 : 64'(len);
            a = umag(dr);
            n = a / lw;
            r = a % lw;
            if (2 * r > lw || (2 * r == lw && n[0]))
                n++;
            res = longint'(a) - longint'(n * lw);
            return dr < 0 ? -res : res;
        endfunction

        static function logic [63:0] int_sqrt(logic [63:0] v);
            logic [63:0] r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        // floor(n * 2^28 / d), capped at 2^40, signed by num
        static function longint param_quot(longint num, longint den);
            logic [63:0] n, rem, q, cap;
            int k;
            logic bt;
            n = umag(num);
            rem = 0;
            q = 0;
            cap = 64'd1 << 40;
            for (k = 0; k < 92; k++)
            begin
                bt = k < 64 ? n[63 - k] : 1'b0;
                rem = (rem << 1) | 64'(bt);
                if (q > cap)
                begin
                    q = cap;
                    break;
                end
                q <<= 1;
                if (rem >= 64'(den))
                begin
                    rem -= 64'(den);
                    q[0] = 1'b1;
                end
            end
            if (q > cap)
                q = cap;
            return num < 0 ? -longint'(q) : longint'(q);
        endfunction

        static function longint sat_axis(logic signed [15:0] v);
            longint x;
            x = v;
            if (x > 16384) return 16384;
            if (x < -16384) return -16384;
            return x;
        endfunction

        static function longint half_len(logic [15:0] asp, logic [15:0] dia);
            if (asp <= ONE_Q8)
                return 0;
            return longint'((64'(asp) - 256) * 64'(dia) / 2);
        endfunction

        static function longint sign_like(longint v, longint s);
            if (s == 0) return 0;
            return s < 0 ? -v : v;
        endfunction

        function dist_res_t predict(pair_t p);
            dist_res_t o;
            longint rx, ry, eix, eiy, ejx, ejy, rei, rej, ee, lhi, lhj;
            longint den, lam, mu, a1, a2, d30;
            logic [63:0] rsq, s, dsq, m, sq, nearlim, rt;
            logic sat;
            int k;
            rx = min_image(longint'(p.pjx) - longint'(p.pix), box_len);
            ry = min_image(longint'(p.pjy) - longint'(p.piy), box_len);
            rsq = umag(rx) * umag(rx) + umag(ry) * umag(ry);
            s = int_sqrt(rsq);
            nearlim = 21 * (64'(cut_asp) * 64'(cut_dia));
            if (!(20 * s < nearlim))
            begin
                o.dval = s > 64'(DIST_MAX) ? DIST_MAX : s[31:0];
                o.near = 1'b0;
                return o;
            end
            eix = sat_axis(p.eix);
            eiy = sat_axis(p.eiy);
            ejx = sat_axis(p.ejx);
            ejy = sat_axis(p.ejy);
            rei = rshift_rnd(rx * eix + ry * eiy, 14);
            rej = rshift_rnd(rx * ejx + ry * ejy, 14);
            ee = eix * ejx + eiy * ejy;
            lhi = half_len(p.asi, p.dii);
            lhj = half_len(p.asj, p.dij);
            den = (longint'(1) << 56) - ee * ee;
            if (den <= EPS_Q56)
            begin
                lam = rei / 2;
                mu = -rej / 2;
            end
            else
            begin
                lam = param_quot(rei * (longint'(1) << 28) - ee * rej, den);
                mu = param_quot(ee * rei - rej * (longint'(1) << 28), den);
            end
            // clamp the line parameters to the half lengths
            if (longint'(umag(lam)) > lhi || longint'(umag(mu)) > lhj)
            begin
                a1 = longint'(umag(lam)) - lhi;
                a2 = longint'(umag(mu)) - lhj;
                if (a1 > a2)
                begin
                    lam = sign_like(lhi, lam);
                    mu = rshift_rnd(lam * ee, 28) - rej;
                    if (longint'(umag(mu)) > lhj)
                        mu = sign_like(lhj, mu);
                end
                else
                begin
                    mu = sign_like(lhj, mu);
                    lam = rshift_rnd(mu * ee, 28) + rei;
                    if (longint'(umag(lam)) > lhi)
                        lam = sign_like(lhi, lam);
                end
            end
            sat = 1'b0;
            dsq = 0;
            for (k = 0; k < 2; k++)
            begin
                if (k == 0)
                    d30 = rx * 16384 + mu * ejx - lam * eix;
                else
                    d30 = ry * 16384 + mu * ejy - lam * eiy;
                m = umag(rshift_rnd(d30, 14));
                if (m > 64'(DIST_MAX))
                    sat = 1'b1;
                else
                begin
                    sq = m * m;
                    if (dsq > ~64'd0 - sq)
                        sat = 1'b1;
                    else
                        dsq += sq;
                end
            end
            rt = int_sqrt(dsq);
            o.dval = sat ? DIST_MAX : rt[31:0];
            o.near = 1'b1;
            return o;
        endfunction

        function void note_pair(pair_t p);
            pending.push_back(predict(p));
        endfunction

        // returns 0 on a mismatch or an unexpected result, 1 otherwise; msg explains the mismatch
        function bit check_result(logic [31:0] dval, logic near, output string msg);
            dist_res_t e;
            n_checked++;
            if (pending.size() == 0)
            begin
                msg = $sformatf("unexpected result dist=%h near=%b", dval, near);
                return 0;
            end
            e = pending.pop_front();
            if (dval !== e.dval || near !== e.near)
            begin
                msg = $sformatf("result %0d: dist=%h near=%b, want dist=%h near=%b",
                                n_checked, dval, near, e.dval, e.near);
                return 0;
            end
            return 1;
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    logic signed [31:0] pos_i_x = 0, pos_i_y = 0, pos_j_x = 0, pos_j_y = 0;
    logic signed [15:0] axis_i_x = 0, axis_i_y = 0, axis_j_x = 0, axis_j_y = 0;
    logic [15:0] aspect_i = 0, diameter_i = 0, aspect_j = 0, diameter_j = 0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic [31:0] distance;
    logic near_pair;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = 2'd0;
    logic [31:0] cfg_data = 32'd0;

    pair_distance_board board;
    int n_errors = 0;
    int n_near = 0;
    int n_items = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    spherocylinder_pair_distance_top uut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        $display("MISMATCH: %s", msg);
        n_errors++;
    endtask

    // output side: random stall, check each transfer
    always @(posedge clk)
    begin
        string msg;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (near_pair)
                    n_near++;
                if (!board.check_result(distance, near_pair, msg))
                    report_mismatch(msg);
            end
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_reg(idx, val);
    endtask

    task automatic send_pair(pair_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        pos_i_x <= p.pix;
        pos_i_y <= p.piy;
        pos_j_x <= p.pjx;
        pos_j_y <= p.pjy;
        axis_i_x <= p.eix;
        axis_i_y <= p.eiy;
        axis_j_x <= p.ejx;
        axis_j_y <= p.ejy;
        aspect_i <= p.asi;
        diameter_i <= p.dii;
        aspect_j <= p.asj;
        diameter_j <= p.dij;
        do
            @(posedge clk);
        while (item_stall);
        board.note_pair(p);
        n_items++;
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(5))
            0: return 16'($urandom_range(16384));
            1: return -16'($urandom_range(16384));
            2: return 16'($urandom);
            3: return 16'sd16384;
            4: return -16'sd16384;
            default: return 16'sd0;
        endcase
    endfunction

    // mostly pairs within reach of each other so the segment path gets exercised
    function automatic pair_t rand_pair();
        pair_t p;
        int ang;
        p.pix = $urandom;
        p.piy = $urandom;
        if ($urandom_range(9) < 7)
        begin
            p.pjx = p.pix + $signed(32'($urandom_range(262144))) - 131072;
            p.pjy = p.piy + $signed(32'($urandom_range(262144))) - 131072;
        end
        else
        begin
            p.pjx = $urandom;
            p.pjy = $urandom;
        end
        ang = $urandom_range(3);
        p.eix = rand_axis();
        p.eiy = rand_axis();
        p.ejx = (ang == 0) ? p.eix : rand_axis();
        p.ejy = (ang == 0) ? p.eiy : rand_axis();
        p.asi = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(1024));
        p.asj = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(1024));
        p.dii = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(512));
        p.dij = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(512));
        return p;
    endfunction

    function automatic pair_t make_pair(int dx, int dy, logic signed [15:0] ax,
                                        logic signed [15:0] ay, logic signed [15:0] bx,
                                        logic signed [15:0] by, logic [15:0] asp,
                                        logic [15:0] dia);
        pair_t p;
        p.pix = 32'sh0001_0000;
        p.piy = -32'sh0002_0000;
        p.pjx = p.pix + dx;
        p.pjy = p.piy + dy;
        p.eix = ax;
        p.eiy = ay;
        p.ejx = bx;
        p.ejy = by;
        p.asi = asp;
        p.dii = dia;
        p.asj = asp;
        p.dij = dia;
        return p;
    endfunction

    task automatic directed_set();
        pair_t p;
        send_pair(make_pair(0, 0, 16384, 0, 0, 16384, 768, 256));
        send_pair(make_pair(32768, 0, 16384, 0, 16384, 0, 768, 256));     // parallel
        send_pair(make_pair(32768, 16384, 16384, 0, -16384, 0, 768, 256)); // antiparallel
        send_pair(make_pair(65536, 65536, 16384, 0, 0, 16384, 1024, 512));
        send_pair(make_pair(131072, 0, 0, 16384, 0, 16384, 200, 256));    // aspect below one
        send_pair(make_pair(16384, 0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 0, 512, 256));
        send_pair(make_pair(-40000, 20000, 11585, 11585, -11585, 11585, 65535, 65535));
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 256, 1));
        send_pair(make_pair(200000, -100000, 16384, 0, 0, 16384, 65535, 65535));
        p = make_pair(0, 0, 16384, 0, 16384, 0, 512, 256);
        p.pix = 32'sh8000_0000;
        p.piy = 32'sh7FFF_FFFF;
        p.pjx = 32'sh7FFF_FFFF;
        p.pjy = 32'sh8000_0000;
        send_pair(p);
        p.pix = 32'sh0020_0000;
        p.pjx = 0;
        p.piy = 0;
        p.pjy = 0;
        send_pair(p); // half box tie
        send_pair(make_pair(5000000, 5000000, 16384, 0, 0, 16384, 512, 256)); // far
    endtask

    initial
    begin
        int ph;
        board = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_set();
        drain();
        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 77; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 77; end
                3: begin send_idle_pct = 32; stall_pct = 32; end
                default: begin send_idle_pct = $urandom_range(50); stall_pct = 20; end
            endcase
            // register settings across phases, extremes included
            case (ph)
                0: write_reg(REG_BOX_LENGTH, 32'd0);
                1: write_reg(REG_BOX_LENGTH, 32'd65536);
                2: write_reg(REG_BOX_LENGTH, 32'h7FFF_FFFF);
                default: write_reg(REG_BOX_LENGTH, $urandom_range(32'h7FFF_FFFF, 65536));
            endcase
            case (ph)
                0: write_reg(REG_CUTOFF_ASPECT, 16'd65535);
                1: write_reg(REG_CUTOFF_ASPECT, 16'd256);
                default: write_reg(REG_CUTOFF_ASPECT, $urandom_range(2048, 256));
            endcase
            case (ph)
                0: write_reg(REG_CUTOFF_DIAMETER, 16'd65535);
                1: write_reg(REG_CUTOFF_DIAMETER, 16'd1);
                default: write_reg(REG_CUTOFF_DIAMETER, $urandom_range(2048, 1));
            endcase
            repeat (250)
                send_pair(rand_pair());
            drain();
        end
        $display("Sent %0d pairs over 6 phases of register settings and idle/stall mixes;",
                 n_items);
        $display("%0d results took the segment path.", n_near);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
